[rtl/sgll_pkg.sv]
// shared types, constants and codes for the seeded geodesic level labeler
package sgll_pkg;

   localparam int IDX_W       = 16;
   localparam int LVL_W       = 16;
   localparam int DIMW_W      = 7;
   localparam int DIMD_W      = 5;
   localparam int AREA_W      = 2 * DIMW_W;
   localparam int NPIX_W      = IDX_W + 1;
   localparam int STORE_DEPTH = 1 << IDX_W;
   localparam int NB_W        = 20;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_DEPTH  = 3'd2;
   localparam logic [2:0] REG_FACE   = 3'd3;
   localparam logic [2:0] REG_PLANAR = 3'd4;
   localparam logic [2:0] REG_LIMIT  = 3'd5;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_DEPTH  = 16;

   // one flood queue entry: pixel, its coordinates and its level
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [DIMW_W-1:0] x;
      logic [DIMW_W-1:0] y;
      logic [DIMD_W-1:0] z;
      logic [LVL_W-1:0]  lvl;
   } sgll_qent_type;

   typedef struct packed {
      logic clr_write;
      logic item_take;
      logic rsp_load;
      logic scan_start;
      logic scan_read;
      logic scan_write;
      logic q_read;
      logic q_load;
      logic nb_issue;
      logic nb_test;
      logic nb_next;
   } sgll_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic item_run;
      logic scan_last;
      logic q_empty;
      logic q_expand;
      logic nb_valid;
      logic nb_last;
      logic cfg_wr;
   } sgll_stat_type;

endpackage

[rtl/sgll_dp.sv]
// datapath: registers, pixel, level and queue memories, scan and neighbor logic
module sgll_dp #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_DEPTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sgll_pkg::ADDR_W-1:0]         paddr,
   input  logic [sgll_pkg::DATA_W-1:0]         pwdata,
   output logic [sgll_pkg::DATA_W-1:0]         prdata,
   input  logic [1:0]                          req_func,
   input  logic [sgll_pkg::IDX_W-1:0]          req_pixel_index,
   input  logic                                req_foreground,
   input  logic                                req_is_seed,
   output logic [sgll_pkg::LVL_W-1:0]          rsp_level,
   output logic                                rsp_status,
   input  sgll_pkg::sgll_cmd_type              cmd,
   output sgll_pkg::sgll_stat_type             stat
);
   import sgll_pkg::*;

   logic [DIMW_W-1:0] width_ff, height_ff;
   logic [DIMD_W-1:0] depth_ff;
   logic              face_ff, planar_ff;
   logic [LVL_W-1:0]  limit_ff;
   logic              cfg_wr;

   logic [DIMW_W-1:0] ew, eh;
   logic [DIMD_W-1:0] ed;
   logic              flat;
   logic [AREA_W-1:0] area_ff;
   logic [NPIX_W-1:0] npix_ff;
   logic [AREA_W+DIMD_W-1:0] prod;

   logic [1:0]        pixel_mem [STORE_DEPTH];
   logic [LVL_W-1:0]  level_mem [STORE_DEPTH];
   sgll_qent_type     queue_mem [STORE_DEPTH];

   logic [1:0]        pix_rd_ff;
   logic [LVL_W-1:0]  lvl_rd_ff;
   sgll_qent_type     q_rd_ff;
   logic [IDX_W-1:0]  pix_ra, lvl_ra, pix_wa, lvl_wa;
   logic              pix_we, lvl_we, q_we;
   logic [LVL_W-1:0]  lvl_wd;
   sgll_qent_type     q_wd;

   logic [IDX_W-1:0]  clr_cnt_ff;
   logic [1:0]        item_func_ff;
   logic              item_in_ff;
   logic              req_in;
   logic [LVL_W-1:0]  rsp_level_ff;
   logic              rsp_status_ff;

   logic [IDX_W-1:0]  scan_i_ff;
   logic [DIMW_W-1:0] sx_ff, sy_ff;
   logic [DIMD_W-1:0] sz_ff;
   logic              seed;

   logic [NPIX_W-1:0] head_ff, tail_ff;
   sgll_qent_type     cur_ff;
   logic [1:0]        ox_ff, oy_ff, oz_ff;
   logic [1:0]        nb_span;
   logic              bounds_ok;
   logic [NB_W-1:0]   xd, yd, zd, nb_full;
   logic [IDX_W-1:0]  nb_ff;
   logic [DIMW_W-1:0] nbx_ff, nby_ff;
   logic [DIMD_W-1:0] nbz_ff;
   logic [LVL_W-1:0]  nl;
   logic              hit;

   // configuration registers
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIMW_W'(1);
         height_ff <= DIMW_W'(1);
         depth_ff  <= DIMD_W'(1);
         face_ff   <= 1'b0;
         planar_ff <= 1'b0;
         limit_ff  <= '0;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            REG_WIDTH:  width_ff  <= pwdata[DIMW_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[DIMW_W-1:0];
            REG_DEPTH:  depth_ff  <= pwdata[DIMD_W-1:0];
            REG_FACE:   face_ff   <= pwdata[0];
            REG_PLANAR: planar_ff <= pwdata[0];
            REG_LIMIT:  limit_ff  <= pwdata[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_WIDTH:  prdata = DATA_W'(width_ff);
         REG_HEIGHT: prdata = DATA_W'(height_ff);
         REG_DEPTH:  prdata = DATA_W'(depth_ff);
         REG_FACE:   prdata = DATA_W'(face_ff);
         REG_PLANAR: prdata = DATA_W'(planar_ff);
         REG_LIMIT:  prdata = DATA_W'(limit_ff);
         default:    prdata = '0;
      endcase
   end

   // effective dimensions: zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (width_ff == '0) ew = DIMW_W'(1);
      else if (11'(width_ff) > 11'(MAX_WIDTH)) ew = DIMW_W'(MAX_WIDTH);
      else ew = width_ff;
      if (height_ff == '0) eh = DIMW_W'(1);
      else if (11'(height_ff) > 11'(MAX_HEIGHT)) eh = DIMW_W'(MAX_HEIGHT);
      else eh = height_ff;
      if (depth_ff == '0) ed = DIMD_W'(1);
      else if (11'(depth_ff) > 11'(MAX_DEPTH)) ed = DIMD_W'(MAX_DEPTH);
      else ed = depth_ff;
   end

   assign flat = (ed == DIMD_W'(1)) || planar_ff;
   assign prod = AREA_W'(area_ff) * (AREA_W+DIMD_W)'(ed);

   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(ew) * AREA_W'(eh);
      if (prod > (AREA_W+DIMD_W)'(STORE_DEPTH)) npix_ff <= NPIX_W'(STORE_DEPTH);
      else npix_ff <= NPIX_W'(prod);
   end

   // memories
   assign req_in = {1'b0, req_pixel_index} < npix_ff;
   assign pix_we = cmd.item_take && (req_func == FUNC_WRITE) && req_in;
   assign pix_wa = req_pixel_index;
   assign pix_ra = cmd.nb_issue ? nb_full[IDX_W-1:0] : scan_i_ff;
   assign lvl_ra = cmd.nb_issue ? nb_full[IDX_W-1:0] : req_pixel_index;

   always_ff @(posedge clock) begin
      if (pix_we) pixel_mem[pix_wa] <= {req_is_seed, req_foreground};
      pix_rd_ff <= pixel_mem[pix_ra];
   end

   always_ff @(posedge clock) begin
      if (lvl_we) level_mem[lvl_wa] <= lvl_wd;
      lvl_rd_ff <= level_mem[lvl_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) queue_mem[tail_ff[IDX_W-1:0]] <= q_wd;
      q_rd_ff <= queue_mem[head_ff[IDX_W-1:0]];
   end

   assign seed = (pix_rd_ff == 2'b11);
   assign hit  = pix_rd_ff[0] && (lvl_rd_ff == '0);
   assign nl   = (cur_ff.lvl == '1) ? cur_ff.lvl : cur_ff.lvl + LVL_W'(1);

   always_comb begin
      lvl_we = 1'b0;
      lvl_wa = clr_cnt_ff;
      lvl_wd = '0;
      q_we   = 1'b0;
      q_wd   = '{idx: scan_i_ff, x: sx_ff, y: sy_ff, z: sz_ff, lvl: LVL_W'(1)};
      if (cmd.clr_write) begin
         lvl_we = 1'b1;
      end else if (cmd.scan_write) begin
         lvl_we = 1'b1;
         lvl_wa = scan_i_ff;
         lvl_wd = LVL_W'(seed);
         q_we   = seed;
      end else if (cmd.nb_test && hit) begin
         lvl_we = 1'b1;
         lvl_wa = nb_ff;
         lvl_wd = nl;
         q_we   = 1'b1;
         q_wd   = '{idx: nb_ff, x: nbx_ff, y: nby_ff, z: nbz_ff, lvl: nl};
      end
   end

   // clearing pass and item handling
   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else if (cmd.clr_write) clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.item_take) begin
         item_func_ff <= req_func;
         item_in_ff   <= req_in;
      end
      if (cmd.rsp_load) begin
         rsp_level_ff  <= (item_func_ff == FUNC_READ && item_in_ff) ? lvl_rd_ff : '0;
         rsp_status_ff <= (item_func_ff == FUNC_WRITE || item_func_ff == FUNC_READ)
                          && !item_in_ff;
      end
   end

   assign rsp_level  = rsp_level_ff;
   assign rsp_status = rsp_status_ff;

   // seed scan counters walk index and coordinates together
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_i_ff <= '0;
         sx_ff     <= '0;
         sy_ff     <= '0;
         sz_ff     <= '0;
      end else if (cmd.scan_write) begin
         scan_i_ff <= scan_i_ff + IDX_W'(1);
         if (sx_ff == ew - DIMW_W'(1)) begin
            sx_ff <= '0;
            if (sy_ff == eh - DIMW_W'(1)) begin
               sy_ff <= '0;
               sz_ff <= sz_ff + DIMD_W'(1);
            end else begin
               sy_ff <= sy_ff + DIMW_W'(1);
            end
         end else begin
            sx_ff <= sx_ff + DIMW_W'(1);
         end
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         if (cmd.q_read) head_ff <= head_ff + NPIX_W'(1);
         if (q_we) tail_ff <= tail_ff + NPIX_W'(1);
      end
   end

   // current pixel and neighbor offsets (0,1,2 stand for -1,0,+1)
   always_ff @(posedge clock) begin
      if (cmd.q_load) begin
         cur_ff <= q_rd_ff;
         ox_ff  <= 2'd0;
         oy_ff  <= 2'd0;
         oz_ff  <= flat ? 2'd1 : 2'd0;
      end else if (cmd.nb_next) begin
         if (ox_ff != 2'd2) begin
            ox_ff <= ox_ff + 2'd1;
         end else begin
            ox_ff <= 2'd0;
            if (oy_ff != 2'd2) begin
               oy_ff <= oy_ff + 2'd1;
            end else begin
               oy_ff <= 2'd0;
               oz_ff <= oz_ff + 2'd1;
            end
         end
      end
      if (cmd.nb_issue) begin
         nb_ff  <= nb_full[IDX_W-1:0];
         nbx_ff <= cur_ff.x + DIMW_W'(ox_ff) - DIMW_W'(1);
         nby_ff <= cur_ff.y + DIMW_W'(oy_ff) - DIMW_W'(1);
         nbz_ff <= cur_ff.z + DIMD_W'(oz_ff) - DIMD_W'(1);
      end
   end

   always_comb begin
      case (ox_ff)
         2'd0:    xd = '1;
         2'd2:    xd = NB_W'(1);
         default: xd = '0;
      endcase
      case (oy_ff)
         2'd0:    yd = -NB_W'(ew);
         2'd2:    yd = NB_W'(ew);
         default: yd = '0;
      endcase
      case (oz_ff)
         2'd0:    zd = -NB_W'(area_ff);
         2'd2:    zd = NB_W'(area_ff);
         default: zd = '0;
      endcase
   end

   assign nb_full = NB_W'(cur_ff.idx) + xd + yd + zd;
   assign nb_span = 2'(ox_ff != 2'd1) + 2'(oy_ff != 2'd1) + 2'(oz_ff != 2'd1);

   always_comb begin
      bounds_ok = 1'b1;
      if (ox_ff == 2'd0 && cur_ff.x == '0) bounds_ok = 1'b0;
      if (ox_ff == 2'd2 && cur_ff.x == ew - DIMW_W'(1)) bounds_ok = 1'b0;
      if (oy_ff == 2'd0 && cur_ff.y == '0) bounds_ok = 1'b0;
      if (oy_ff == 2'd2 && cur_ff.y == eh - DIMW_W'(1)) bounds_ok = 1'b0;
      if (oz_ff == 2'd0 && cur_ff.z == '0) bounds_ok = 1'b0;
      if (oz_ff == 2'd2 && cur_ff.z == ed - DIMD_W'(1)) bounds_ok = 1'b0;
   end

   assign stat.clr_last  = (clr_cnt_ff == '1);
   assign stat.item_run  = (item_func_ff == FUNC_RUN);
   assign stat.scan_last = ({1'b0, scan_i_ff} + NPIX_W'(1)) == npix_ff;
   assign stat.q_empty   = (head_ff == tail_ff);
   assign stat.q_expand  = (limit_ff == '0) || (q_rd_ff.lvl < limit_ff);
   assign stat.nb_valid  = (nb_span != 2'd0) && !(face_ff && nb_span != 2'd1) && bounds_ok
                           && (nb_full < NB_W'(npix_ff));
   assign stat.nb_last   = (ox_ff == 2'd2) && (oy_ff == 2'd2)
                           && (oz_ff == (flat ? 2'd1 : 2'd2));
   assign stat.cfg_wr    = cfg_wr;

endmodule

[rtl/sgll_ctrl.sv]
// controller: sequences clearing, item handling, seed scan and flood
module sgll_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sgll_pkg::sgll_cmd_type   cmd,
   input  sgll_pkg::sgll_stat_type  stat
);
   import sgll_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ITEM,
      ST_SCAN_RD,
      ST_SCAN_WR,
      ST_Q_RD,
      ST_Q_LOAD,
      ST_NB_ADDR,
      ST_NB_TEST
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] settle_ff, settle_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   // size registers need to settle after a write, so requests stall until they have
   assign req_stall  = !(state_ff == ST_IDLE && settle_ff == 2'd0
                         && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               cmd.item_take = 1'b1;
               state_in = ST_ITEM;
            end
         end
         ST_ITEM: begin
            if (stat.item_run) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN_RD;
            end else begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in = ST_SCAN_WR;
         end
         ST_SCAN_WR: begin
            cmd.scan_write = 1'b1;
            state_in = stat.scan_last ? ST_Q_RD : ST_SCAN_RD;
         end
         ST_Q_RD: begin
            if (stat.q_empty) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.q_read = 1'b1;
               state_in = ST_Q_LOAD;
            end
         end
         ST_Q_LOAD: begin
            cmd.q_load = 1'b1;
            state_in = stat.q_expand ? ST_NB_ADDR : ST_Q_RD;
         end
         ST_NB_ADDR: begin
            if (stat.nb_valid) begin
               cmd.nb_issue = 1'b1;
               state_in = ST_NB_TEST;
            end else begin
               cmd.nb_next = 1'b1;
               if (stat.nb_last) state_in = ST_Q_RD;
            end
         end
         ST_NB_TEST: begin
            cmd.nb_test = 1'b1;
            cmd.nb_next = 1'b1;
            state_in = stat.nb_last ? ST_Q_RD : ST_NB_ADDR;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      settle_in = settle_ff;
      if (stat.cfg_wr) settle_in = 2'd2;
      else if (settle_ff != 2'd0) settle_in = settle_ff - 2'd1;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         settle_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/seeded_geodesic_level_labeler_top.sv]
// top level of the seeded geodesic level labeler
//
//  channel  | handshake            | payload
//  req      | req_valid/req_stall  | req_func, req_pixel_index, req_foreground, req_is_seed
//  rsp      | rsp_valid/rsp_stall  | rsp_level, rsp_status
//  csr      | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// a pixel write, a level read or an unused code passes the item state and loads its result
// from the registered memory read; a labeling run scans every pixel for seeds in a read and
// a write state, then per queued pixel reads and loads its entry, and for one that expands
// visits each neighbor offset (9 or 27), testing those that pass border and face checks.
// after reset a clearing pass zeroes all 65536 entries of the level memory, req_stall high.
// req_stall stays high after a register write while sizes settle.
// a stalled result holds; the next item is taken in the cycle the result transfers.
module seeded_geodesic_level_labeler_top #(
   parameter int MAX_WIDTH  = sgll_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sgll_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_DEPTH  = sgll_pkg::DEF_MAX_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [sgll_pkg::IDX_W-1:0]  req_pixel_index,
   input  logic                        req_foreground,
   input  logic                        req_is_seed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sgll_pkg::LVL_W-1:0]  rsp_level,
   output logic                        rsp_status,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sgll_pkg::ADDR_W-1:0] paddr,
   input  logic [sgll_pkg::DATA_W-1:0] pwdata,
   output logic [sgll_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import sgll_pkg::*;

   sgll_cmd_type  cmd;
   sgll_stat_type stat;

   assign pready = 1'b1;

   sgll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   sgll_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .req_func        (req_func),
      .req_pixel_index (req_pixel_index),
      .req_foreground  (req_foreground),
      .req_is_seed     (req_is_seed),
      .rsp_level       (rsp_level),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

[rtl/sgll_checker.sv]
// port-level checks for the labeler top, attached by bind
module sgll_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [sgll_pkg::LVL_W-1:0]  rsp_level,
   input logic                        rsp_status
);
   import sgll_pkg::*;

   // clearing pass blocks items right after reset
   a_stall_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken right after reset");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on consecutive cycles");

   a_status_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_level == '0))
      else $error("out-of-volume result with nonzero level");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_level) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind seeded_geodesic_level_labeler_top sgll_checker u_sgll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_level  (rsp_level),
   .rsp_status (rsp_status)
);
